// ===== rtl/pidq_pkg.sv =====
`default_nettype none
package pidq_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_W    = 64;
    localparam int GAIN_W    = 32;
    localparam int ERR_W     = 16;
    localparam int MS_W      = 32;
    localparam int RAMP_W    = 16;
    localparam int LIM_W     = 15;
    localparam int PER_W     = 16;
    localparam int DRIVE_W   = 32;
    localparam int ADDR_W    = 5;
    localparam int APB_W     = 32;

    localparam logic [WORD_W-1:0] ALPHA_Q     = WORD_W'((64'd10923 << FRAC_BITS) >> 16);
    localparam logic [WORD_W-1:0] HALF_Q      = WORD_W'(64'd1 << (FRAC_BITS - 1));
    localparam logic [MS_W-1:0]   DT_MAX_MS   = MS_W'(500000);
    localparam logic [MS_W-1:0]   DT_DEF_MS   = MS_W'(1000);
    localparam logic [WORD_W-1:0] MS_PER_SEC  = WORD_W'(1000);

    typedef enum logic [2:0] {
        REG_PROP_GAIN  = 3'd0,
        REG_INTEG_GAIN = 3'd1,
        REG_DERIV_GAIN = 3'd2,
        REG_RAMP_RATE  = 3'd3,
        REG_OUT_LIMIT  = 3'd4,
        REG_SAMPLE_MS  = 3'd5
    } reg_idx_t;

endpackage
`default_nettype wire

// ===== rtl/pidq_mul.sv =====
`default_nettype none
module pidq_mul (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pidq_pkg::WORD_W-1:0] a,
    input  logic [pidq_pkg::WORD_W-1:0] b,
    output logic                        done,
    output logic [pidq_pkg::WORD_W-1:0] result
);
    import pidq_pkg::*;

    localparam int CNT_W = $clog2(WORD_W);

    logic [WORD_W-1:0] ua_reg;
    logic [WORD_W-1:0] hi_reg;
    logic [WORD_W-1:0] lo_reg;
    logic              neg_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [WORD_W:0]   sum;
    logic [WORD_W-1:0] prod_q;
    logic              low_zero;

    // one multiplier bit per cycle, product shifts right through hi:lo
    assign sum      = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, ua_reg} : '0);
    assign prod_q   = {hi_reg[FRAC_BITS-1:0], lo_reg[WORD_W-1:FRAC_BITS]};
    assign low_zero = (lo_reg[FRAC_BITS-1:0] == '0);
    assign result   = neg_reg ? (~prod_q + WORD_W'(low_zero)) : prod_q;
    assign done     = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(WORD_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ua_reg  <= a[WORD_W-1] ? -a : a;
            lo_reg  <= b[WORD_W-1] ? -b : b;
            hi_reg  <= '0;
            neg_reg <= a[WORD_W-1] ^ b[WORD_W-1];
        end
        else if (busy_reg)
        begin
            hi_reg <= sum[WORD_W:1];
            lo_reg <= {sum[0], lo_reg[WORD_W-1:1]};
        end
    end

endmodule
`default_nettype wire

// ===== rtl/pidq_div.sv =====
`default_nettype none
module pidq_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pidq_pkg::WORD_W-1:0] a,
    input  logic [pidq_pkg::WORD_W-1:0] b,
    output logic                        done,
    output logic [pidq_pkg::WORD_W-1:0] result
);
    import pidq_pkg::*;

    localparam int NUM_W = WORD_W + FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W);

    logic [NUM_W-1:0]  num_reg;
    logic [WORD_W-1:0] rem_reg;
    logic [WORD_W-1:0] q_reg;
    logic [WORD_W-1:0] ub_reg;
    logic              neg_reg;
    logic              zero_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [WORD_W:0]   rem_sh;
    logic [WORD_W:0]   diff;
    logic              fits;

    // restoring division, one quotient bit per cycle
    assign rem_sh = {rem_reg, num_reg[NUM_W-1]};
    assign diff   = rem_sh - {1'b0, ub_reg};
    assign fits   = (rem_sh >= {1'b0, ub_reg});
    assign result = zero_reg ? '0 : (neg_reg ? -q_reg : q_reg);
    assign done   = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= {(a[WORD_W-1] ? -a : a), {FRAC_BITS{1'b0}}};
            ub_reg   <= b[WORD_W-1] ? -b : b;
            zero_reg <= (b == '0);
            neg_reg  <= a[WORD_W-1] ^ b[WORD_W-1];
            rem_reg  <= '0;
            q_reg    <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg <= fits ? diff[WORD_W-1:0] : rem_sh[WORD_W-1:0];
            q_reg   <= {q_reg[WORD_W-2:0], fits};
        end
    end

endmodule
`default_nettype wire

// ===== rtl/pid_q16_filtered_ramp_limited.sv =====
// channel  | signals                                   | direction
// ---------+-------------------------------------------+----------
// input    | in_valid, in_ready, op, error, elapsed_ms | in
// output   | out_valid, out_ready, drive               | out
// config   | psel, penable, pwrite, paddr, pwdata,     | in
//          | prdata, pready                            |
//
// an update item runs two bit-serial divisions and six bit-serial multiplications one after
// the other before it shows out_valid; the ramp limit adds a third division with its
// multiply alongside
// a clear item goes straight to S_WRITE and shows out_valid once the output register is free
// rst_n clears all controller state and top-level registers at once, no sweep
// one item at a time; while out_ready is low a result waits in the output register
// and a newer result waits in its last state until that register frees
`default_nettype none
module pid_q16_filtered_ramp_limited (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          op,
    input  logic signed [pidq_pkg::ERR_W-1:0] error,
    input  logic [pidq_pkg::MS_W-1:0]     elapsed_ms,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [pidq_pkg::DRIVE_W-1:0] drive,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pidq_pkg::ADDR_W-1:0]   paddr,
    input  logic [pidq_pkg::APB_W-1:0]    pwdata,
    output logic [pidq_pkg::APB_W-1:0]    prdata,
    output logic                          pready
);
    import pidq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DTS, S_PROP, S_I1, S_I2, S_I3, S_D1, S_D2, S_D3,
        S_SUM, S_RAMP, S_RATE, S_WRITE
    } state_t;

    state_t             state_reg;
    logic [GAIN_W-1:0]  prop_gain_reg;
    logic [GAIN_W-1:0]  integ_gain_reg;
    logic [GAIN_W-1:0]  deriv_gain_reg;
    logic [RAMP_W-1:0]  ramp_rate_reg;
    logic [LIM_W-1:0]   out_limit_reg;
    logic [PER_W-1:0]   sample_ms_reg;

    logic [ERR_W-1:0]   last_error_reg;
    logic [WORD_W-1:0]  integ_acc_reg;
    logic [WORD_W-1:0]  last_output_reg;
    logic [WORD_W-1:0]  deriv_filt_reg;

    logic               clr_reg;
    logic [ERR_W-1:0]   err_reg;
    logic [WORD_W-1:0]  dts_reg;
    logic [WORD_W-1:0]  prop_reg;
    logic [WORD_W-1:0]  integ_reg;
    logic [WORD_W-1:0]  sum_reg;
    logic [WORD_W-1:0]  outv_reg;
    logic               out_valid_reg;
    logic [DRIVE_W-1:0] drive_reg;

    logic               mul_start_reg;
    logic [WORD_W-1:0]  mul_a_reg;
    logic [WORD_W-1:0]  mul_b_reg;
    logic               mul_done;
    logic [WORD_W-1:0]  mul_res;
    logic               div_start_reg;
    logic [WORD_W-1:0]  div_a_reg;
    logic [WORD_W-1:0]  div_b_reg;
    logic               div_done;
    logic [WORD_W-1:0]  div_res;

    logic               cfg_wr;
    reg_idx_t           cfg_idx;
    logic [MS_W-1:0]    dt_ms;
    logic [WORD_W-1:0]  lim;
    logic [WORD_W-1:0]  ramp_q;
    logic               lim_on;
    logic [ERR_W:0]     err_sum;
    logic [ERR_W:0]     err_dif;
    logic [WORD_W-1:0]  err_fix;
    logic [WORD_W-1:0]  sum_fix;
    logic [WORD_W-1:0]  dif_fix;
    logic [WORD_W-1:0]  outv_sum;
    logic [DRIVE_W-1:0] drive_sat;
    logic               out_free;

    function automatic logic [WORD_W-1:0] clamp_lim(input logic [WORD_W-1:0] v,
                                                     input logic [WORD_W-1:0] l);
        logic [WORD_W-1:0] r;
        r = v;
        if ($signed(v) > $signed(l))
            r = l;
        else if ($signed(v) < $signed(-l))
            r = -l;
        return r;
    endfunction

    pidq_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start_reg),
        .a      (mul_a_reg),
        .b      (mul_b_reg),
        .done   (mul_done),
        .result (mul_res)
    );

    pidq_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start_reg),
        .a      (div_a_reg),
        .b      (div_b_reg),
        .done   (div_done),
        .result (div_res)
    );

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;
    assign cfg_idx   = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;
    assign out_free  = !out_valid_reg || out_ready;

    assign lim    = WORD_W'(out_limit_reg) << FRAC_BITS;
    assign ramp_q = WORD_W'(ramp_rate_reg) << FRAC_BITS;
    assign lim_on = (out_limit_reg != '0);

    always_comb
    begin
        if (sample_ms_reg != '0)
            dt_ms = MS_W'(sample_ms_reg);
        else if (elapsed_ms == '0 || elapsed_ms > DT_MAX_MS)
            dt_ms = DT_DEF_MS;
        else
            dt_ms = elapsed_ms;
    end

    assign err_sum  = {err_reg[ERR_W-1], err_reg} + {last_error_reg[ERR_W-1], last_error_reg};
    assign err_dif  = {err_reg[ERR_W-1], err_reg} - {last_error_reg[ERR_W-1], last_error_reg};
    assign err_fix  = {{(WORD_W-ERR_W){err_reg[ERR_W-1]}}, err_reg} << FRAC_BITS;
    assign sum_fix  = {{(WORD_W-ERR_W-1){err_sum[ERR_W]}}, err_sum} << FRAC_BITS;
    assign dif_fix  = {{(WORD_W-ERR_W-1){err_dif[ERR_W]}}, err_dif} << FRAC_BITS;
    assign outv_sum = sum_reg + deriv_filt_reg;

    // floor of the fixed-point value, saturated to the drive range
    always_comb
    begin
        if (outv_reg[WORD_W-1:FRAC_BITS+DRIVE_W-1] == '0 ||
            outv_reg[WORD_W-1:FRAC_BITS+DRIVE_W-1] == '1)
            drive_sat = outv_reg[FRAC_BITS+DRIVE_W-1:FRAC_BITS];
        else if (outv_reg[WORD_W-1])
            drive_sat = {1'b1, {(DRIVE_W-1){1'b0}}};
        else
            drive_sat = {1'b0, {(DRIVE_W-1){1'b1}}};
    end

    always_comb
    begin
        case (cfg_idx)
            REG_PROP_GAIN:  prdata = prop_gain_reg;
            REG_INTEG_GAIN: prdata = integ_gain_reg;
            REG_DERIV_GAIN: prdata = deriv_gain_reg;
            REG_RAMP_RATE:  prdata = APB_W'(ramp_rate_reg);
            REG_OUT_LIMIT:  prdata = APB_W'(out_limit_reg);
            REG_SAMPLE_MS:  prdata = APB_W'(sample_ms_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            prop_gain_reg   <= '0;
            integ_gain_reg  <= '0;
            deriv_gain_reg  <= '0;
            ramp_rate_reg   <= '0;
            out_limit_reg   <= '0;
            sample_ms_reg   <= '0;
            last_error_reg  <= '0;
            integ_acc_reg   <= '0;
            last_output_reg <= '0;
            deriv_filt_reg  <= '0;
            clr_reg         <= 1'b0;
            err_reg         <= '0;
            dts_reg         <= '0;
            prop_reg        <= '0;
            integ_reg       <= '0;
            sum_reg         <= '0;
            outv_reg        <= '0;
            out_valid_reg   <= 1'b0;
            drive_reg       <= '0;
            mul_start_reg   <= 1'b0;
            mul_a_reg       <= '0;
            mul_b_reg       <= '0;
            div_start_reg   <= 1'b0;
            div_a_reg       <= '0;
            div_b_reg       <= '0;
        end
        else
        begin
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;

            if (cfg_wr)
            begin
                case (cfg_idx)
                    REG_PROP_GAIN:  prop_gain_reg  <= pwdata[GAIN_W-1:0];
                    REG_INTEG_GAIN: integ_gain_reg <= pwdata[GAIN_W-1:0];
                    REG_DERIV_GAIN: deriv_gain_reg <= pwdata[GAIN_W-1:0];
                    REG_RAMP_RATE:  ramp_rate_reg  <= pwdata[RAMP_W-1:0];
                    REG_OUT_LIMIT:  out_limit_reg  <= pwdata[LIM_W-1:0];
                    REG_SAMPLE_MS:  sample_ms_reg  <= pwdata[PER_W-1:0];
                    default:        ;
                endcase
            end

            if (out_valid_reg && out_ready && state_reg != S_WRITE)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        err_reg <= error;
                        clr_reg <= op;
                        if (op)
                            state_reg <= S_WRITE;
                        else
                        begin
                            div_a_reg     <= WORD_W'(dt_ms);
                            div_b_reg     <= MS_PER_SEC;
                            div_start_reg <= 1'b1;
                            state_reg     <= S_DTS;
                        end
                    end
                end
                S_DTS:
                begin
                    if (div_done)
                    begin
                        dts_reg       <= (div_res == '0) ? WORD_W'(1) : div_res;
                        mul_a_reg     <= {{(WORD_W-GAIN_W){prop_gain_reg[GAIN_W-1]}},
                                          prop_gain_reg};
                        mul_b_reg     <= err_fix;
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_PROP;
                    end
                end
                S_PROP:
                begin
                    if (mul_done)
                    begin
                        prop_reg      <= mul_res;
                        mul_a_reg     <= {{(WORD_W-GAIN_W){integ_gain_reg[GAIN_W-1]}},
                                          integ_gain_reg};
                        mul_b_reg     <= dts_reg;
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_I1;
                    end
                end
                S_I1:
                begin
                    if (mul_done)
                    begin
                        mul_a_reg     <= mul_res;
                        mul_b_reg     <= sum_fix;
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_I2;
                    end
                end
                S_I2:
                begin
                    if (mul_done)
                    begin
                        mul_a_reg     <= mul_res;
                        mul_b_reg     <= HALF_Q;
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_I3;
                    end
                end
                S_I3:
                begin
                    if (mul_done)
                    begin
                        integ_reg     <= lim_on ? clamp_lim(integ_acc_reg + mul_res, lim)
                                                : integ_acc_reg + mul_res;
                        mul_a_reg     <= {{(WORD_W-GAIN_W){deriv_gain_reg[GAIN_W-1]}},
                                          deriv_gain_reg};
                        mul_b_reg     <= dif_fix;
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_D1;
                    end
                end
                S_D1:
                begin
                    if (mul_done)
                    begin
                        div_a_reg     <= mul_res;
                        div_b_reg     <= dts_reg;
                        div_start_reg <= 1'b1;
                        state_reg     <= S_D2;
                    end
                end
                S_D2:
                begin
                    if (div_done)
                    begin
                        mul_a_reg     <= ALPHA_Q;
                        mul_b_reg     <= div_res - deriv_filt_reg;
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_D3;
                    end
                end
                S_D3:
                begin
                    if (mul_done)
                    begin
                        deriv_filt_reg <= deriv_filt_reg + mul_res;
                        sum_reg        <= prop_reg + integ_reg;
                        state_reg      <= S_SUM;
                    end
                end
                S_SUM:
                begin
                    outv_reg  <= lim_on ? clamp_lim(outv_sum, lim) : outv_sum;
                    state_reg <= (ramp_rate_reg != '0) ? S_RAMP : S_WRITE;
                end
                S_RAMP:
                begin
                    div_a_reg     <= outv_reg - last_output_reg;
                    div_b_reg     <= dts_reg;
                    div_start_reg <= 1'b1;
                    mul_a_reg     <= ramp_q;
                    mul_b_reg     <= dts_reg;
                    mul_start_reg <= 1'b1;
                    state_reg     <= S_RATE;
                end
                S_RATE:
                begin
                    // the multiply finishes first and holds its result
                    if (div_done)
                    begin
                        if ($signed(div_res) > $signed(ramp_q))
                            outv_reg <= last_output_reg + mul_res;
                        else if ($signed(div_res) < $signed(-ramp_q))
                            outv_reg <= last_output_reg - mul_res;
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (clr_reg)
                        begin
                            drive_reg       <= '0;
                            last_error_reg  <= '0;
                            integ_acc_reg   <= '0;
                            last_output_reg <= '0;
                            deriv_filt_reg  <= '0;
                        end
                        else
                        begin
                            drive_reg       <= drive_sat;
                            last_error_reg  <= err_reg;
                            integ_acc_reg   <= integ_reg;
                            last_output_reg <= outv_reg;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/pidq_checker.sv =====
`default_nettype none
module pidq_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic                               op,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic [pidq_pkg::DRIVE_W-1:0]       drive,
    input  logic                               pready
);
    import pidq_pkg::*;

    // one item at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while an item is in work");

    // a clear item taken while out_valid is low gives drive zero by way of S_WRITE
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && op && !out_valid) |=> ##1 (out_valid && drive == '0))
        else $error("clear item did not give zero drive");

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(drive)))
        else $error("result changed under stall");

    assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind pid_q16_filtered_ramp_limited pidq_checker u_pidq_checker (.*);
`default_nettype wire
